// ----- rtl/h264_rtp_depacketizer_defines.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef H264_RTP_DEPACKETIZER_DEFINES_SVH
`define H264_RTP_DEPACKETIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RTPD_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("rtpd assertion failed");

// Next-cycle implication, checked out of reset.
`define RTPD_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("rtpd assertion failed");

`endif

// ----- rtl/rtpd_pkg.sv -----
`default_nettype none
package rtpd_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam logic [4:0] KIND_STAP = 5'd24;
  localparam logic [4:0] KIND_FU   = 5'd28;
  localparam logic [7:0] TYPE_MASK = 8'h1F;

  localparam logic [11:0] START_SAT = 12'hFFF;
  localparam logic [11:0] POS_SAT   = 12'hFFF;

  // STAP-A aggregate phases
  localparam logic [1:0] AGG_SIZE_HI = 2'd0;
  localparam logic [1:0] AGG_SIZE_LO = 2'd1;
  localparam logic [1:0] AGG_BODY    = 2'd2;
  localparam logic [1:0] AGG_STOP    = 2'd3;

  // One queued command: what a single input word produces.
  typedef struct packed {
    logic        start;    // 00 00 00 01
    logic        byte_en;  // one stream byte
    logic [7:0]  val;
    logic        done;     // frame summary
    logic        empty;
    logic [31:0] ts;
    logic [6:0]  pt;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/rtpd_front.sv -----
`default_nettype none
module rtpd_front #(
  parameter int MAX_PACKET_BYTES = rtpd_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire logic [7:0]   b,
  input  wire logic         pfirst,
  input  wire logic         plast,
  input  wire logic         ffirst,
  input  wire logic         flast,
  input  wire logic [11:0]  plen,
  input  wire logic [7:0]   ptrail,
  output logic              push,
  output rtpd_pkg::cmd_t    cmd
);

  logic [15:0] exp_r, exp_nxt;
  logic        fcont_r, fcont_nxt;
  logic [11:0] pos_r, pos_nxt;
  logic [11:0] pstart_r, pstart_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic        skip_r, skip_nxt;
  logic [4:0]  kind_r, kind_nxt;
  logic [7:0]  fui_r, fui_nxt;
  logic [1:0]  aph_r, aph_nxt;
  logic [15:0] arem_r, arem_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [6:0]  ptype_r, ptype_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic [11:0] len_r, len_nxt;
  logic [11:0] end_r, end_nxt;
  logic [7:0]  trail_r, trail_nxt;
  logic        ff_r, ff_nxt;

  always_comb begin
    logic [11:0] p;
    logic [7:0]  h0;
    logic [7:0]  base;
    logic [7:0]  base0;
    logic [7:0]  pad;
    logic [15:0] seq;
    logic [15:0] ext;
    logic [18:0] s;
    logic [15:0] size;
    logic [11:0] clamped;
    exp_nxt = exp_r; fcont_nxt = fcont_r; pos_nxt = pos_r; pstart_nxt = pstart_r;
    hdr_nxt = hdr_r; skip_nxt = skip_r; kind_nxt = kind_r; fui_nxt = fui_r;
    aph_nxt = aph_r; arem_nxt = arem_r; stamp_nxt = stamp_r; ptype_nxt = ptype_r;
    nonempty_nxt = nonempty_r; len_nxt = len_r; end_nxt = end_r;
    trail_nxt = trail_r; ff_nxt = ff_r;
    cmd = '0;
    p = '0; h0 = '0; base = '0; base0 = '0; pad = '0; seq = '0; ext = '0;
    s = '0; size = '0;
    clamped = ({5'd0, plen} > 17'(MAX_PACKET_BYTES)) ? 12'(MAX_PACKET_BYTES) : plen;
    if (acc) begin
      if (pfirst) begin
        len_nxt = clamped; trail_nxt = ptrail; end_nxt = '0; ff_nxt = ffirst;
        pos_nxt = '0; pstart_nxt = rtpd_pkg::START_SAT; hdr_nxt = '0;
        skip_nxt = 1'b0; kind_nxt = '0; aph_nxt = rtpd_pkg::AGG_SIZE_HI; arem_nxt = '0;
        if (ffirst) begin
          exp_nxt = '0; fcont_nxt = 1'b0; stamp_nxt = '0; ptype_nxt = '0;
          nonempty_nxt = 1'b0;
        end
      end
      p = pos_nxt;
      if (p < len_nxt) begin
        // header section
        if (p < 12'd12 || p < pstart_nxt) begin
          h0 = hdr_nxt[23:16];
          base = 8'd12 + {2'b00, h0[3:0], 2'b00};
          if (ff_nxt) begin
            if (p == 12'd1) ptype_nxt = b[6:0];
            if (p >= 12'd4 && p <= 12'd7) stamp_nxt = {stamp_nxt[23:0], b};
          end
          if (p == 12'd0) begin
            hdr_nxt = {b, 16'd0};
            base0 = 8'd12 + {2'b00, b[3:0], 2'b00};
            if (len_nxt < {4'd0, base0}) skip_nxt = 1'b1;
            pstart_nxt = {4'd0, base0} + (b[4] ? 12'd4 : 12'd0);
            pad = b[5] ? trail_nxt : 8'd0;
            end_nxt = (len_nxt > {4'd0, pad}) ? len_nxt - {4'd0, pad} : 12'd0;
          end else if (p == 12'd2) begin
            hdr_nxt[15:8] = b;
          end else if (p == 12'd3) begin
            seq = {hdr_nxt[15:8], b};
            if (ff_nxt) exp_nxt = seq;
            if (!skip_nxt) begin
              if (seq < exp_nxt) skip_nxt = 1'b1;
              else begin
                if (seq > exp_nxt) fcont_nxt = 1'b0;
                exp_nxt = seq + 16'd1;
              end
            end
          end
          if (h0[4] && p >= 12'd12) begin
            if (p == {4'd0, base} + 12'd2) begin
              hdr_nxt[7:0] = b;
            end else if (p == {4'd0, base} + 12'd3) begin
              ext = {hdr_nxt[7:0], b};
              s = {11'd0, base} + 19'd4 + {1'b0, ext, 2'b00};
              pstart_nxt = (s > {7'd0, rtpd_pkg::START_SAT}) ? rtpd_pkg::START_SAT : s[11:0];
            end
          end
        end
        // payload section
        if (!skip_nxt && p >= pstart_nxt && p < end_nxt) begin
          if (p == pstart_nxt) begin
            kind_nxt = b[4:0] & rtpd_pkg::TYPE_MASK[4:0];
            if (kind_nxt == rtpd_pkg::KIND_FU) begin
              fui_nxt = b;
              aph_nxt = rtpd_pkg::AGG_SIZE_HI;
              if ({1'b0, end_nxt} <= {1'b0, p} + 13'd1) skip_nxt = 1'b1;
            end else begin
              fcont_nxt = 1'b0;
              if (kind_nxt == rtpd_pkg::KIND_STAP) aph_nxt = rtpd_pkg::AGG_SIZE_HI;
              else if (kind_nxt >= 5'd1 && kind_nxt < rtpd_pkg::KIND_STAP) begin
                cmd.start = 1'b1; cmd.byte_en = 1'b1; cmd.val = b;
              end else skip_nxt = 1'b1;
            end
          end else if (kind_nxt == rtpd_pkg::KIND_FU) begin
            if ({1'b0, p} == {1'b0, pstart_nxt} + 13'd1) begin
              if (b[7]) begin
                cmd.start = 1'b1; cmd.byte_en = 1'b1;
                cmd.val = (fui_nxt & 8'h60) | (b & rtpd_pkg::TYPE_MASK);
                fcont_nxt = 1'b1;
              end
              aph_nxt = {1'b0, fcont_nxt};
              if (b[6]) fcont_nxt = 1'b0;
            end else if (aph_nxt != 2'd0) begin
              cmd.byte_en = 1'b1; cmd.val = b;
            end
          end else if (kind_nxt == rtpd_pkg::KIND_STAP) begin
            case (aph_nxt)
              rtpd_pkg::AGG_SIZE_HI: begin
                if ({1'b0, p} + 13'd2 < {1'b0, end_nxt}) begin
                  arem_nxt = {8'd0, b}; aph_nxt = rtpd_pkg::AGG_SIZE_LO;
                end else aph_nxt = rtpd_pkg::AGG_STOP;
              end
              rtpd_pkg::AGG_SIZE_LO: begin
                size = {arem_nxt[7:0], b};
                if (size == 16'd0 ||
                    {6'd0, p} + 18'd1 + {2'd0, size} > {6'd0, end_nxt}) begin
                  aph_nxt = rtpd_pkg::AGG_STOP;
                end else begin
                  cmd.start = 1'b1; arem_nxt = size; aph_nxt = rtpd_pkg::AGG_BODY;
                end
              end
              rtpd_pkg::AGG_BODY: begin
                cmd.byte_en = 1'b1; cmd.val = b;
                arem_nxt = arem_nxt - 16'd1;
                if (arem_nxt == 16'd0) aph_nxt = rtpd_pkg::AGG_SIZE_HI;
              end
              default: ;
            endcase
          end else begin
            cmd.byte_en = 1'b1; cmd.val = b;
          end
        end
      end
      if (pos_nxt != rtpd_pkg::POS_SAT) pos_nxt = pos_nxt + 12'd1;
      if (cmd.start || cmd.byte_en) nonempty_nxt = 1'b1;
      if (plast) begin
        len_nxt = '0; end_nxt = '0;
        if (flast) begin
          cmd.done = 1'b1;
          cmd.empty = !nonempty_nxt;
          cmd.ts = nonempty_nxt ? stamp_nxt : 32'd0;
          cmd.pt = nonempty_nxt ? ptype_nxt : 7'd0;
          nonempty_nxt = 1'b0;
        end
      end
    end
    push = acc && (cmd.start || cmd.byte_en || cmd.done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0; fcont_r <= 1'b0; pos_r <= '0; pstart_r <= '0; hdr_r <= '0;
      skip_r <= 1'b0; kind_r <= '0; fui_r <= '0; aph_r <= rtpd_pkg::AGG_SIZE_HI;
      arem_r <= '0; stamp_r <= '0; ptype_r <= '0; nonempty_r <= 1'b0;
      len_r <= '0; end_r <= '0; trail_r <= '0; ff_r <= 1'b0;
    end else begin
      exp_r <= exp_nxt; fcont_r <= fcont_nxt; pos_r <= pos_nxt; pstart_r <= pstart_nxt;
      hdr_r <= hdr_nxt; skip_r <= skip_nxt; kind_r <= kind_nxt; fui_r <= fui_nxt;
      aph_r <= aph_nxt; arem_r <= arem_nxt; stamp_r <= stamp_nxt; ptype_r <= ptype_nxt;
      nonempty_r <= nonempty_nxt; len_r <= len_nxt; end_r <= end_nxt;
      trail_r <= trail_nxt; ff_r <= ff_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rtpd_queue.sv -----
`default_nettype none
module rtpd_queue #(
  parameter int DEPTH = rtpd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  rtpd_pkg::cmd_t   wdata,
  output logic             full,
  input  wire logic        pop,
  output logic             valid,
  output rtpd_pkg::cmd_t   head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtpd_pkg::cmd_t    mem_r [DEPTH];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    if (pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rtpd_back.sv -----
`default_nettype none
module rtpd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  rtpd_pkg::cmd_t   q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tlast,
  output logic [2:0]       out_tuser
);

  typedef enum logic [5:0] {
    PH_SC0  = 6'b000001,
    PH_SC1  = 6'b000010,
    PH_SC2  = 6'b000100,
    PH_SC3  = 6'b001000,
    PH_BYTE = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  phase_t      ph_r, ph_nxt, cur;
  logic        busy_r, busy_nxt;
  logic        vld_r, vld_nxt;
  logic [47:0] data_r, data_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  user_r, user_nxt;
  logic        adv;
  logic        fin;
  phase_t      nx;

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;
  assign adv        = !vld_r || out_tready;

  always_comb begin
    if (busy_r)                cur = ph_r;
    else if (q_head.start)     cur = PH_SC0;
    else if (q_head.byte_en)   cur = PH_BYTE;
    else                       cur = PH_DONE;
    fin = 1'b0;
    nx  = PH_DONE;
    unique case (cur)
      PH_SC0:  nx = PH_SC1;
      PH_SC1:  nx = PH_SC2;
      PH_SC2:  nx = PH_SC3;
      PH_SC3:  begin
        if (q_head.byte_en) nx = PH_BYTE;
        else if (q_head.done) nx = PH_DONE;
        else fin = 1'b1;
      end
      PH_BYTE: begin
        if (q_head.done) nx = PH_DONE;
        else fin = 1'b1;
      end
      PH_DONE: fin = 1'b1;
      default: fin = 1'b1;
    endcase
  end

  always_comb begin
    ph_nxt = ph_r; busy_nxt = busy_r; vld_nxt = vld_r;
    data_nxt = data_r; last_nxt = last_r; user_nxt = user_r;
    q_pop = 1'b0;
    if (adv) begin
      vld_nxt = q_valid;
      if (q_valid) begin
        data_nxt = '0; last_nxt = 1'b0; user_nxt = '0;
        unique case (cur)
          PH_SC0:  user_nxt = 3'b011;
          PH_SC1, PH_SC2: user_nxt = 3'b001;
          PH_SC3:  begin user_nxt = 3'b001; data_nxt[7:0] = 8'd1; end
          PH_BYTE: begin user_nxt = 3'b001; data_nxt[7:0] = q_head.val; end
          PH_DONE: begin
            last_nxt = 1'b1;
            user_nxt = {q_head.empty, 2'b00};
            data_nxt[39:8]  = q_head.ts;
            data_nxt[46:40] = q_head.pt;
          end
          default: ;
        endcase
        if (fin) begin
          q_pop = 1'b1; busy_nxt = 1'b0;
        end else begin
          busy_nxt = 1'b1; ph_nxt = nx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      ph_r <= PH_SC0; busy_r <= 1'b0; vld_r <= 1'b0; last_r <= 1'b0; user_r <= '0;
    end else begin
      ph_r <= ph_nxt; busy_r <= busy_nxt; vld_r <= vld_nxt;
      last_r <= last_nxt; user_r <= user_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/h264_rtp_depacketizer.sv -----
// Path: a word's first result is written into the command queue when the word is accepted,
//   then into the output register before it shows as out_tvalid.
// Throughput: one input word per cycle while the queue is not full; a start code expands into
//   four output words, so a word that opens a NAL unit yields four to six; the queue absorbs it.
// Reset: synchronous active-low rst_n clears all parse state, queue pointers and out valid.
`default_nettype none
`include "h264_rtp_depacketizer_defines.svh"
module h264_rtp_depacketizer #(
  parameter int MAX_PACKET_BYTES = rtpd_pkg::MAX_PACKET_BYTES_DEF,
  parameter int QUEUE_DEPTH      = rtpd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // data_byte[7:0], packet_length[19:8], trailing_byte[27:20]
  input  wire logic        in_tlast,  // packet_last
  input  wire logic [2:0]  in_tuser,  // packet_first[0], frame_first[1], frame_last[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // out_byte[7:0], frame_timestamp[39:8], frame_payload_type[46:40]
  output logic             out_tlast, // frame_done
  output logic [2:0]       out_tuser  // byte_valid[0], start_code_first[1], frame_empty[2]
);

  logic           q_full, q_valid, q_pop, push, acc;
  rtpd_pkg::cmd_t cmd, head;

  // front parses one packet byte per accepted word
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  rtpd_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk, .rst_n, .acc,
    .b(in_tdata[7:0]), .pfirst(in_tuser[0]), .plast(in_tlast),
    .ffirst(in_tuser[1]), .flast(in_tuser[2]),
    .plen(in_tdata[19:8]), .ptrail(in_tdata[27:20]),
    .push, .cmd
  );

  // command queue decouples parsing from start-code expansion
  rtpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .wdata(cmd), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head
  );

  // back end expands each command into output words
  rtpd_back u_back (
    .clk, .rst_n, .q_valid, .q_head(head), .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  `RTPD_ASSERT_NOW(a_push_room, push, !q_full)
  `RTPD_ASSERT_NOW(a_pop_has, q_pop, q_valid)
  `RTPD_ASSERT_NOW(a_sc_is_byte, out_tvalid && out_tuser[1], out_tuser[0] && !out_tlast)
  `RTPD_ASSERT_NEXT(a_push_fills, push && !q_pop, q_valid)

endmodule
`default_nettype wire
